/* src/g2h_pkg.sv */
// Shared types, constants and lookup functions for the Gregorian to Hijri date core.
// No dependencies; the top level refers to it by scoped names.

package g2h_pkg;

    // sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MUL100 = 10'b00_0000_0010,
        S_ABS    = 10'b00_0000_0100,
        S_EST    = 10'b00_0000_1000,
        S_YLD    = 10'b00_0001_0000,
        S_UPM    = 10'b00_0010_0000,
        S_UPC    = 10'b00_0100_0000,
        S_DNM    = 10'b00_1000_0000,
        S_DNC    = 10'b01_0000_0000,
        S_MON    = 10'b10_0000_0000
    } state_t;

    // absolute day number of the Islamic epoch
    localparam logic [23:0] ISL_EPOCH   = 24'd227014;
    // epoch offset of the first day of a Hijri year, day number minus year start
    localparam logic [23:0] YEAR_BIAS   = 24'd353;
    localparam logic [23:0] DAYS_COMMON = 24'd354;

    // reciprocals for the shared multiplier
    // y / 100    = (y * RECIP_100) >> 19
    // y / 30     = (y * RECIP_30) >> 24
    // year guess = (days * RECIP_YEAR) >> 32, about 30 / 10631
    localparam logic [23:0] RECIP_100  = 24'd5243;
    localparam logic [23:0] RECIP_30   = 24'd559241;
    localparam logic [23:0] RECIP_YEAR = 24'd12120122;

    localparam logic [3:0] LAST_MONTH = 4'd12;

    // days in the Gregorian months before month m, common year
    function automatic logic [8:0] greg_cum(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd396;
            4'd15:   d = 9'd427;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // days of the Hijri year before month m
    function automatic logic [8:0] hij_month_off(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd30;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd89;
            4'd5:    d = 9'd118;
            4'd6:    d = 9'd148;
            4'd7:    d = 9'd177;
            4'd8:    d = 9'd207;
            4'd9:    d = 9'd236;
            4'd10:   d = 9'd266;
            4'd11:   d = 9'd295;
            4'd12:   d = 9'd325;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* src/gregorian_to_tabular_islamic_date_core.sv */
// Gregorian to tabular Islamic (Hijri) date converter, top level.
// Depends on g2h_pkg for the state type, constants and month tables.
//
//  channel   direction  signals                     payload
//  s_*       in         s_tvalid s_tready s_tdata   greg_day, greg_month, greg_year
//  m_*       out        m_tvalid m_tready m_tdata   hijri_day, hijri_month, hijri_year
//  cfg_*     in         cfg_wr_en cfg_wr_data       day_adjust (signed 3 bits)
//
// A date is converted in steps: states S_MUL100, S_ABS, S_EST and S_YLD form the day number
// and year guess, the year is then checked upward and downward on the one shared multiplier,
// then the months are stepped through and the result is loaded.
// s_tready is high only while the sequencer is idle, so a new date waits until the last is loaded.
// The output register holds a finished result while m_tready is low; the next date
// is accepted meanwhile and its finish waits until that register is free.
// rst_n clears the sequencer, the output valid and day_adjust.

module gregorian_to_tabular_islamic_date_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // greg_day[4:0], greg_month[8:5], greg_year[22:9], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // hijri_day[6:0], hijri_month[10:7], hijri_year[24:11], zero
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data
);

    g2h_pkg::state_t state_reg, state_next;

    logic [4:0]  gd_reg;
    logic [3:0]  gm_reg;
    logic [13:0] gy_reg;
    logic [22:0] acc_reg, acc_next;
    logic [47:0] prod_reg;
    logic [23:0] dp_reg, dp_next;
    logic [14:0] y_reg, y_next;
    logic [8:0]  doy_reg, doy_next;
    logic [3:0]  month_reg, month_next;
    logic [2:0]  adj_reg;

    logic        out_valid_reg, out_valid_next;
    logic [6:0]  hday_reg, hday_next;
    logic [3:0]  hmon_reg, hmon_next;
    logic [13:0] hyear_reg, hyear_next;

    logic        in_fire;
    logic [23:0] mul_a, mul_b;
    logic [13:0] py;
    logic [7:0]  q100, py100;
    logic [5:0]  py400;
    logic        rem_zero, leap, leap_add, sat;
    logic [23:0] abs_day;
    logic [14:0] yc;
    logic [17:0] n30;
    logic [13:0] q30;
    logic [23:0] tstart;
    logic [3:0]  month_inc;
    logic [8:0]  off_next, off_cur;
    logic [9:0]  hday_wide;
    logic        out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == g2h_pkg::S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg <= 3'd0;
        end
        else if (cfg_wr_en)
        begin
            adj_reg <= cfg_wr_data;
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = 24'd0;
        mul_b = 24'd0;
        case (state_reg)
            g2h_pkg::S_MUL100:
            begin
                mul_a = 24'(gy_reg);
                mul_b = g2h_pkg::RECIP_100;
            end
            g2h_pkg::S_EST:
            begin
                mul_a = dp_reg;
                mul_b = g2h_pkg::RECIP_YEAR;
            end
            g2h_pkg::S_UPM, g2h_pkg::S_DNM:
            begin
                mul_a = 24'(n30);
                mul_b = g2h_pkg::RECIP_30;
            end
            default:
            begin
                mul_a = 24'd0;
                mul_b = 24'd0;
            end
        endcase
    end

    // gregorian day number pieces
    assign py       = gy_reg - 14'd1;
    assign acc_next = 23'(py) * 23'd365 + 23'(py >> 2)
                    + 23'(g2h_pkg::greg_cum(gm_reg)) + 23'(gd_reg);

    // century corrections and leap year from the y / 100 product
    assign q100     = prod_reg[26:19];
    assign rem_zero = (gy_reg == 14'(14'(q100) * 14'd100));
    assign py100    = q100 - {7'd0, rem_zero};
    assign py400    = py100[7:2];
    assign leap     = (gy_reg[1:0] == 2'd0) && (!rem_zero || (q100[1:0] == 2'd0));
    assign leap_add = leap && (gm_reg > 4'd2);
    assign abs_day  = 24'(acc_reg) + 24'(leap_add) - 24'(py100) + 24'(py400);
    assign sat      = (gy_reg == 14'd0) || (abs_day < g2h_pkg::ISL_EPOCH);
    assign dp_next  = sat ? g2h_pkg::YEAR_BIAS
                          : abs_day - g2h_pkg::ISL_EPOCH + g2h_pkg::YEAR_BIAS;

    // hijri year start relative to the epoch, plus bias, for candidate year yc
    assign yc     = ((state_reg == g2h_pkg::S_UPM) || (state_reg == g2h_pkg::S_UPC))
                    ? 15'(y_reg + 15'd1) : y_reg;
    assign n30    = 18'd3 + 18'(yc) * 18'd11;
    assign q30    = prod_reg[37:24];
    assign tstart = 24'(yc) * g2h_pkg::DAYS_COMMON + 24'(q30);

    // month step and day of month
    assign month_inc = 4'(month_reg + 4'd1);
    assign off_next  = g2h_pkg::hij_month_off(month_inc);
    assign off_cur   = g2h_pkg::hij_month_off(month_reg);
    assign hday_wide = 10'(doy_reg - off_cur) + 10'd1 + {{7{adj_reg[2]}}, adj_reg};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        y_next         = y_reg;
        doy_next       = doy_reg;
        month_next     = month_reg;
        out_valid_next = out_valid_reg && !m_tready;
        hday_next      = hday_reg;
        hmon_next      = hmon_reg;
        hyear_next     = hyear_reg;
        case (state_reg)
            g2h_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = g2h_pkg::S_MUL100;
                end
            end
            g2h_pkg::S_MUL100:
            begin
                state_next = g2h_pkg::S_ABS;
            end
            g2h_pkg::S_ABS:
            begin
                state_next = g2h_pkg::S_EST;
            end
            g2h_pkg::S_EST:
            begin
                state_next = g2h_pkg::S_YLD;
            end
            g2h_pkg::S_YLD:
            begin
                y_next     = prod_reg[46:32];
                state_next = g2h_pkg::S_UPM;
            end
            g2h_pkg::S_UPM:
            begin
                state_next = g2h_pkg::S_UPC;
            end
            g2h_pkg::S_UPC:
            begin
                // next year still starts on or before this day
                if (tstart <= dp_reg)
                begin
                    y_next     = yc;
                    state_next = g2h_pkg::S_UPM;
                end
                else
                begin
                    state_next = g2h_pkg::S_DNM;
                end
            end
            g2h_pkg::S_DNM:
            begin
                state_next = g2h_pkg::S_DNC;
            end
            g2h_pkg::S_DNC:
            begin
                if (tstart > dp_reg)
                begin
                    y_next     = y_reg - 15'd1;
                    state_next = g2h_pkg::S_DNM;
                end
                else
                begin
                    doy_next   = 9'(dp_reg - tstart);
                    month_next = 4'd1;
                    state_next = g2h_pkg::S_MON;
                end
            end
            g2h_pkg::S_MON:
            begin
                if ((month_reg < g2h_pkg::LAST_MONTH) && (doy_reg >= off_next))
                begin
                    month_next = month_inc;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hday_next      = hday_wide[6:0];
                    hmon_next      = month_reg;
                    hyear_next     = y_reg[13:0];
                    state_next     = g2h_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = g2h_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= g2h_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            gd_reg <= s_tdata[4:0];
            gm_reg <= s_tdata[8:5];
            gy_reg <= s_tdata[22:9];
        end
        if (state_reg == g2h_pkg::S_MUL100)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == g2h_pkg::S_ABS)
        begin
            dp_reg <= dp_next;
        end
        prod_reg  <= mul_a * mul_b;
        y_reg     <= y_next;
        doy_reg   <= doy_next;
        month_reg <= month_next;
        hday_reg  <= hday_next;
        hmon_reg  <= hmon_next;
        hyear_reg <= hyear_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, hyear_reg, hmon_reg, hday_reg};

endmodule

/* src/g2h_checker.sv */
// Port-level checks for the Gregorian to Hijri date core, bound to its top level.
// Depends only on the top level's ports.

module g2h_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // the converter is busy right after taking a date
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while conversion running");

    // no result shows early after a date is taken while no result is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early");

    // hijri month is always a real month
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:7] != 4'd0) && (m_tdata[10:7] <= 4'd12))
        else $error("hijri month out of range");

endmodule

bind gregorian_to_tabular_islamic_date_core g2h_port_checks u_g2h_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
